// ----- src/accumulator_cpu_four_op_step_macros.svh -----
// =============================================================================
// Assertion macros for the accumulator processor
// Shared wrappers that clock every property on clock and drop it during reset.
// =============================================================================
`ifndef ACCUMULATOR_CPU_FOUR_OP_STEP_MACROS_SVH
`define ACCUMULATOR_CPU_FOUR_OP_STEP_MACROS_SVH

// Same-cycle implication.
`define ACPU_ASSERT_NOW(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication.
`define ACPU_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

// ----- src/acpu_pkg.sv -----
// =============================================================================
// acpu_pkg
// Types, codes and helpers shared by the accumulator processor modules.
// =============================================================================
package acpu_pkg;

   localparam int MEM_WORDS    = 64;
   localparam int ADDR_W       = $clog2(MEM_WORDS);
   localparam int FIELD_ADDR_W = 6;
   localparam int DATA_W       = 8;
   localparam int CNT_W        = 32;

   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_STEP  = 2'd1,
      CMD_READ  = 2'd2,
      CMD_RESET = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_NOR = 2'd0,
      OP_ADD = 2'd1,
      OP_STA = 2'd2,
      OP_JCC = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_FETCH,
      ST_EXEC
   } state_type;

   typedef logic [ADDR_W-1:0] addr_type;

   typedef struct packed {
      logic              en;
      logic              we;
      addr_type          addr;
      logic [DATA_W-1:0] wdata;
   } ram_req_type;

   typedef struct packed {
      cmd_type                 command;
      logic [FIELD_ADDR_W-1:0] mem_address;
      logic [DATA_W-1:0]       load_data;
   } req_word_type;

   // Reduce a 6-bit address modulo the memory depth (constant lookup).
   function automatic addr_type wrap_addr(input logic [FIELD_ADDR_W-1:0] a);
      addr_type r;
      r = '0;
      for (int i = 0; i < 2**FIELD_ADDR_W; i++) begin
         if (a == FIELD_ADDR_W'(i)) begin
            r = ADDR_W'(i % MEM_WORDS);
         end
      end
      return r;
   endfunction

   // Advance the program counter, wrapping at the memory depth.
   function automatic addr_type next_pc(input addr_type pc);
      addr_type r;
      if (pc == ADDR_W'(MEM_WORDS - 1)) begin
         r = '0;
      end else begin
         r = pc + ADDR_W'(1);
      end
      return r;
   endfunction

endpackage

// ----- src/accumulator_cpu_four_op_step.sv -----
// =============================================================================
// accumulator_cpu_four_op_step
// Four-opcode accumulator processor with a 64-byte unified memory.
// =============================================================================
// Usage:
//   Drive one command word per req_ handshake: write a memory byte, step one
//   instruction, read a memory byte, or clear the registers (memory kept).
//   Every word returns exactly one rsp_ word with the machine state after it.
//   A word is taken on a rising edge with valid high and stall low.
//   rsp_valid rises through the result register: write and register clear
//   finish in the idle state, read in the read state, store and jump in the
//   fetch state, NOR and ADD in the execute state after fetch. The single
//   memory port sets this order, since fetch, operand read and store write
//   each take one access.
//   A one-word input buffer takes the next word while the sequencer works,
//   and the result register holds a finished word while rsp_stall is high;
//   the sequencer waits at its last step until the result register frees up.
//   Reset clears the registers, counters and both handshakes;
//   memory reads back as zero through per-entry valid bits, with no clear pass.
// =============================================================================
module accumulator_cpu_four_op_step (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_command,
   input  logic [5:0]  req_mem_address,
   input  logic [7:0]  req_load_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [5:0]  rsp_program_counter,
   output logic [7:0]  rsp_accumulator,
   output logic        rsp_carry,
   output logic [1:0]  rsp_executed_opcode,
   output logic        rsp_jump_taken,
   output logic [7:0]  rsp_read_data,
   output logic [31:0] rsp_instruction_count,
   output logic [31:0] rsp_cycle_count
);

   // Input buffer: holds one command word for the sequencer.
   logic                   buf_valid_ff, buf_valid_in;
   acpu_pkg::req_word_type buf_word_ff;
   logic                   req_accept;
   logic                   cmd_take;

   // Memory port between sequencer and RAM.
   acpu_pkg::ram_req_type  ram_req;
   logic [7:0]             ram_rdata;

   // Stall only when the buffer is full and the sequencer does not drain it now.
   assign req_stall    = buf_valid_ff && !cmd_take;
   assign req_accept   = req_valid && !req_stall;
   assign buf_valid_in = req_accept || (buf_valid_ff && !cmd_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
      end else begin
         buf_valid_ff <= buf_valid_in;
      end
   end

   // Capture the payload on accept; hold otherwise.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         buf_word_ff.command     <= acpu_pkg::cmd_type'(req_command);
         buf_word_ff.mem_address <= req_mem_address;
         buf_word_ff.load_data   <= req_load_data;
      end
   end

   acpu_ram u_ram (
      .clock (clock),
      .reset (reset),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   acpu_core u_core (
      .clock                 (clock),
      .reset                 (reset),
      .cmd_valid             (buf_valid_ff),
      .cmd_word              (buf_word_ff),
      .cmd_take              (cmd_take),
      .ram_req               (ram_req),
      .ram_rdata             (ram_rdata),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_program_counter   (rsp_program_counter),
      .rsp_accumulator       (rsp_accumulator),
      .rsp_carry             (rsp_carry),
      .rsp_executed_opcode   (rsp_executed_opcode),
      .rsp_jump_taken        (rsp_jump_taken),
      .rsp_read_data         (rsp_read_data),
      .rsp_instruction_count (rsp_instruction_count),
      .rsp_cycle_count       (rsp_cycle_count)
   );

endmodule

// ----- src/acpu_ram.sv -----
// =============================================================================
// acpu_ram
// Single-port unified memory with registered read and per-entry valid bits.
// =============================================================================
module acpu_ram (
   input  logic                             clock,
   input  logic                             reset,
   input  acpu_pkg::ram_req_type            req,
   output logic [acpu_pkg::DATA_W-1:0]      rdata
);

   logic [acpu_pkg::DATA_W-1:0]    mem_array [acpu_pkg::MEM_WORDS];
   logic [acpu_pkg::MEM_WORDS-1:0] valid_ff;
   logic [acpu_pkg::DATA_W-1:0]    q_ff;
   logic                           q_valid_ff;

   always_ff @(posedge clock) begin
      if (req.en) begin
         if (req.we) begin
            mem_array[req.addr] <= req.wdata;
         end else begin
            q_ff <= mem_array[req.addr];
         end
      end
   end

   // Entries never written since reset read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         q_valid_ff <= 1'b0;
      end else if (req.en) begin
         if (req.we) begin
            valid_ff[req.addr] <= 1'b1;
         end else begin
            q_valid_ff <= valid_ff[req.addr];
         end
      end
   end

   assign rdata = q_valid_ff ? q_ff : '0;

endmodule

// ----- src/acpu_core.sv -----
// =============================================================================
// acpu_core
// Command sequencer, architectural registers and result register.
// =============================================================================
module acpu_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              cmd_valid,
   input  acpu_pkg::req_word_type            cmd_word,
   output logic                              cmd_take,
   output acpu_pkg::ram_req_type             ram_req,
   input  logic [acpu_pkg::DATA_W-1:0]       ram_rdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [acpu_pkg::FIELD_ADDR_W-1:0] rsp_program_counter,
   output logic [acpu_pkg::DATA_W-1:0]       rsp_accumulator,
   output logic                              rsp_carry,
   output logic [1:0]                        rsp_executed_opcode,
   output logic                              rsp_jump_taken,
   output logic [acpu_pkg::DATA_W-1:0]       rsp_read_data,
   output logic [acpu_pkg::CNT_W-1:0]        rsp_instruction_count,
   output logic [acpu_pkg::CNT_W-1:0]        rsp_cycle_count
);

   acpu_pkg::state_type  state_ff, state_in;
   acpu_pkg::addr_type   pc_ff, pc_in;
   logic [acpu_pkg::DATA_W-1:0] acc_ff, acc_in;
   logic                 carry_ff, carry_in;
   logic [acpu_pkg::CNT_W-1:0] icnt_ff, icnt_in, ccnt_ff, ccnt_in;
   acpu_pkg::opcode_type op_ff, op_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   acpu_pkg::addr_type   rsp_pc_ff;
   logic [acpu_pkg::DATA_W-1:0] rsp_acc_ff, rsp_rdata_ff;
   logic                 rsp_carry_ff, rsp_taken_ff;
   acpu_pkg::opcode_type rsp_op_ff;
   logic [acpu_pkg::CNT_W-1:0] rsp_icnt_ff, rsp_ccnt_ff;

   logic                 out_free;
   logic                 finish;
   acpu_pkg::opcode_type res_op;
   logic                 res_taken;
   logic [acpu_pkg::DATA_W-1:0] res_rdata;
   acpu_pkg::opcode_type fetch_op;
   acpu_pkg::addr_type   fetch_opa;
   logic [acpu_pkg::DATA_W:0] sum;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign fetch_op  = acpu_pkg::opcode_type'(ram_rdata[7:6]);
   assign fetch_opa = acpu_pkg::wrap_addr(ram_rdata[5:0]);
   assign sum       = {1'b0, ram_rdata} + {1'b0, acc_ff};

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         acpu_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_word.command)
                  acpu_pkg::CMD_READ: state_in = acpu_pkg::ST_READ;
                  acpu_pkg::CMD_STEP: state_in = acpu_pkg::ST_FETCH;
                  default:            state_in = acpu_pkg::ST_IDLE;
               endcase
            end
         end
         acpu_pkg::ST_READ: begin
            if (out_free) state_in = acpu_pkg::ST_IDLE;
         end
         acpu_pkg::ST_FETCH: begin
            unique case (fetch_op) inside
               acpu_pkg::OP_NOR, acpu_pkg::OP_ADD: state_in = acpu_pkg::ST_EXEC;
               default: begin
                  if (out_free) state_in = acpu_pkg::ST_IDLE;
               end
            endcase
         end
         acpu_pkg::ST_EXEC: begin
            if (out_free) state_in = acpu_pkg::ST_IDLE;
         end
         default: state_in = acpu_pkg::ST_IDLE;
      endcase
   end

   // Outputs, memory requests and register updates.
   always_comb begin
      cmd_take  = 1'b0;
      ram_req   = '0;
      finish    = 1'b0;
      pc_in     = pc_ff;
      acc_in    = acc_ff;
      carry_in  = carry_ff;
      icnt_in   = icnt_ff;
      ccnt_in   = ccnt_ff;
      op_in     = op_ff;
      res_op    = acpu_pkg::OP_NOR;
      res_taken = 1'b0;
      res_rdata = '0;
      unique case (state_ff)
         acpu_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               unique case (cmd_word.command)
                  acpu_pkg::CMD_WRITE: begin
                     if (out_free) begin
                        cmd_take      = 1'b1;
                        finish        = 1'b1;
                        ram_req.en    = 1'b1;
                        ram_req.we    = 1'b1;
                        ram_req.addr  = acpu_pkg::wrap_addr(cmd_word.mem_address);
                        ram_req.wdata = cmd_word.load_data;
                     end
                  end
                  acpu_pkg::CMD_READ: begin
                     cmd_take     = 1'b1;
                     ram_req.en   = 1'b1;
                     ram_req.addr = acpu_pkg::wrap_addr(cmd_word.mem_address);
                  end
                  acpu_pkg::CMD_RESET: begin
                     if (out_free) begin
                        cmd_take = 1'b1;
                        finish   = 1'b1;
                        pc_in    = '0;
                        acc_in   = '0;
                        carry_in = 1'b0;
                        icnt_in  = '0;
                        ccnt_in  = '0;
                     end
                  end
                  default: begin
                     cmd_take     = 1'b1;
                     ram_req.en   = 1'b1;
                     ram_req.addr = pc_ff;
                  end
               endcase
            end
         end
         acpu_pkg::ST_READ: begin
            if (out_free) begin
               finish    = 1'b1;
               res_rdata = ram_rdata;
            end
         end
         acpu_pkg::ST_FETCH: begin
            op_in = fetch_op;
            unique case (fetch_op) inside
               acpu_pkg::OP_NOR, acpu_pkg::OP_ADD: begin
                  ram_req.en   = 1'b1;
                  ram_req.addr = fetch_opa;
               end
               acpu_pkg::OP_STA: begin
                  if (out_free) begin
                     finish        = 1'b1;
                     res_op        = acpu_pkg::OP_STA;
                     ram_req.en    = 1'b1;
                     ram_req.we    = 1'b1;
                     ram_req.addr  = fetch_opa;
                     ram_req.wdata = acc_ff;
                     pc_in         = acpu_pkg::next_pc(pc_ff);
                     icnt_in       = icnt_ff + acpu_pkg::CNT_W'(1);
                     ccnt_in       = ccnt_ff + acpu_pkg::CNT_W'(2);
                  end
               end
               default: begin
                  if (out_free) begin
                     finish   = 1'b1;
                     res_op   = acpu_pkg::OP_JCC;
                     carry_in = 1'b0;
                     icnt_in  = icnt_ff + acpu_pkg::CNT_W'(1);
                     if (!carry_ff) begin
                        pc_in     = fetch_opa;
                        res_taken = 1'b1;
                        ccnt_in   = ccnt_ff + acpu_pkg::CNT_W'(1);
                     end else begin
                        pc_in   = acpu_pkg::next_pc(pc_ff);
                        ccnt_in = ccnt_ff + acpu_pkg::CNT_W'(2);
                     end
                  end
               end
            endcase
         end
         acpu_pkg::ST_EXEC: begin
            if (out_free) begin
               finish  = 1'b1;
               res_op  = op_ff;
               pc_in   = acpu_pkg::next_pc(pc_ff);
               icnt_in = icnt_ff + acpu_pkg::CNT_W'(1);
               ccnt_in = ccnt_ff + acpu_pkg::CNT_W'(2);
               if (op_ff == acpu_pkg::OP_ADD) begin
                  acc_in   = sum[acpu_pkg::DATA_W-1:0];
                  carry_in = sum[acpu_pkg::DATA_W];
               end else begin
                  acc_in = ~(ram_rdata | acc_ff);
               end
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = finish || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acpu_pkg::ST_IDLE;
         pc_ff        <= '0;
         acc_ff       <= '0;
         carry_ff     <= 1'b0;
         icnt_ff      <= '0;
         ccnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         acc_ff       <= acc_in;
         carry_ff     <= carry_in;
         icnt_ff      <= icnt_in;
         ccnt_ff      <= ccnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff <= op_in;
      if (finish) begin
         rsp_pc_ff    <= pc_in;
         rsp_acc_ff   <= acc_in;
         rsp_carry_ff <= carry_in;
         rsp_op_ff    <= res_op;
         rsp_taken_ff <= res_taken;
         rsp_rdata_ff <= res_rdata;
         rsp_icnt_ff  <= icnt_in;
         rsp_ccnt_ff  <= ccnt_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_program_counter   = acpu_pkg::FIELD_ADDR_W'(rsp_pc_ff);
   assign rsp_accumulator       = rsp_acc_ff;
   assign rsp_carry             = rsp_carry_ff;
   assign rsp_executed_opcode   = rsp_op_ff;
   assign rsp_jump_taken        = rsp_taken_ff;
   assign rsp_read_data         = rsp_rdata_ff;
   assign rsp_instruction_count = rsp_icnt_ff;
   assign rsp_cycle_count       = rsp_ccnt_ff;

endmodule

// ----- src/acpu_checker.sv -----
// =============================================================================
// acpu_checker
// Port-level checks on the accumulator processor, bound to the top level.
// =============================================================================
`include "accumulator_cpu_four_op_step_macros.svh"

module acpu_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [5:0]  rsp_program_counter,
   input logic        rsp_carry,
   input logic [1:0]  rsp_executed_opcode,
   input logic        rsp_jump_taken,
   input logic [7:0]  rsp_read_data,
   input logic [31:0] rsp_cycle_count
);

   `ACPU_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_program_counter) && $stable(rsp_cycle_count), "stalled result word changed")
   `ACPU_ASSERT_NOW(a_taken_is_jcc, rsp_valid && rsp_jump_taken, rsp_executed_opcode == acpu_pkg::OP_JCC && !rsp_carry, "jump taken without a jump opcode or with carry set")
   `ACPU_ASSERT_NOW(a_read_not_step, rsp_valid && rsp_read_data != 8'd0, rsp_executed_opcode == acpu_pkg::OP_NOR && !rsp_jump_taken, "read data on a step result")
   `ACPU_ASSERT_NOW(a_reset_empty, $past(reset), !rsp_valid, "result word present right after reset")

endmodule

bind accumulator_cpu_four_op_step acpu_checker u_acpu_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_program_counter (rsp_program_counter),
   .rsp_carry           (rsp_carry),
   .rsp_executed_opcode (rsp_executed_opcode),
   .rsp_jump_taken      (rsp_jump_taken),
   .rsp_read_data       (rsp_read_data),
   .rsp_cycle_count     (rsp_cycle_count)
);
